>>> rtl/bblur_pkg.sv
// Shared types and fixed constants for the horizontal box blur line pass.
package bblur_pkg;

    localparam int CHANNELS        = 4;
    localparam int CH_W            = 8;
    localparam int PIX_W           = CHANNELS * CH_W;
    localparam int SUM_W           = 14;
    localparam int RECIP_W         = 25;
    localparam int FRAC_W          = 24;
    localparam int PROD_W          = SUM_W + RECIP_W;
    localparam int USER_W          = 2;

    localparam int LEN_CFG_W       = 13;
    localparam int FRAME_CFG_W     = 13;
    localparam int RAD_CFG_W       = 5;
    localparam int CFG_DATA_W      = 25;
    localparam int CFG_IDX_W       = 2;

    localparam int FRAME_LINES_MAX = 4096;
    localparam int LINE_CNT_W      = 12;

    localparam int LEN_RESET       = 4096;
    localparam int FRAME_RESET     = 4096;
    localparam int RAD_RESET       = 1;
    localparam int RECIP_RESET     = 5592405;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINES_PER_FRAME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS          = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RECIP    = 2'd3;

    typedef struct packed {
        logic line_end;
        logic frame_end;
        logic run_last;
    } bblur_flags_t;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             first;
        logic             use_mem;
        logic             emit;
        bblur_flags_t     flags;
    } bblur_op_t;

endpackage

>>> rtl/box_blur_line_pass.sv
// Top level of the horizontal box blur line pass over four-channel pixels.
//
// This block blurs a stream of four-channel 8-bit pixels along each line: every
// result is, per channel, the mean of 2*radius+1 pixels centered on it, rounded
// half up, with pixels beyond either end of the line taken as copies of the first
// or last pixel. Results trail the input by radius pixels; the last pixel of a
// line releases the radius remaining results, so it yields radius+1 results.
// One pixel is accepted per clock cycle while the input is not held off. The
// last pixel of a line holds the input off while the flush steps read the
// window memory. A result passes the window sum, sum snapshot, product and
// rounding registers in that order; the last is the output register. The
// window memory holds the last 2*MAX_RADIUS+1 pixels of the line and has one
// write and one read port; its read port is the one shared by the normal and
// the flush steps. Results pass through a chain of handshaked registers, so
// the input keeps flowing while a finished result waits for the sink, until
// the chain is full. Configuration is written through the plain write port;
// the user must do so only while the block is idle, as the block does not
// enforce it: register 0 line_length, 1 lines_per_frame, 2 radius, 3
// window_reciprocal (unsigned Q1.24). Writing line_length or radius abandons a
// partial line. The radius used is clamped to MAX_RADIUS and (line_length-1)/2.
module box_blur_line_pass #(
    parameter int MAX_RADIUS = 31,
    parameter int MAX_LINE   = 4096
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // in_ch0 [7:0], in_ch1 [15:8], in_ch2 [23:16], in_ch3 [31:24]
    input  logic [bblur_pkg::PIX_W-1:0]       s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_ch0 [7:0], out_ch1 [15:8], out_ch2 [23:16], out_ch3 [31:24]
    output logic [bblur_pkg::PIX_W-1:0]       m_tdata,
    // line_end [0], frame_end [1]
    output logic [bblur_pkg::USER_W-1:0]      m_tuser,
    // Set on the last result caused by one input pixel.
    output logic                              m_tlast,
    input  logic                              cfg_wr_en,
    input  logic [bblur_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bblur_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import bblur_pkg::*;

    localparam int LEN_W = $clog2(MAX_LINE + 1);
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int WW    = RW + 1;
    localparam int PTR_W = $clog2(2 * MAX_RADIUS + 1);

    logic [LEN_W-1:0]          len;
    logic [RW-1:0]             r_eff;
    logic [WW-1:0]             win;
    logic [PTR_W-1:0]          start_ptr;
    logic [FRAME_CFG_W-1:0]    frame_len;
    logic [RECIP_W-1:0]        recip;
    logic                      line_clear;

    logic                      ready_b;
    logic                      op_valid;
    bblur_op_t                 op;
    logic                      mem_we;
    logic [PTR_W-1:0]          mem_waddr;
    logic                      mem_re;
    logic [PTR_W-1:0]          mem_raddr;
    logic [PIX_W-1:0]          mem_rdata;

    logic                      res_valid;
    logic [CHANNELS*SUM_W-1:0] res_sums;
    bblur_flags_t              res_flags;
    logic                      c_ready;

    // Register file; effective geometry is settled at the time of the write.
    bblur_cfg #(
        .MAX_RADIUS (MAX_RADIUS),
        .MAX_LINE   (MAX_LINE)
    ) u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .len_o        (len),
        .r_o          (r_eff),
        .win_o        (win),
        .start_o      (start_ptr),
        .frame_o      (frame_len),
        .recip_o      (recip),
        .line_clear_o (line_clear)
    );

    // Column tracking, flush sequencing and window memory addressing.
    bblur_issue #(
        .MAX_RADIUS (MAX_RADIUS),
        .MAX_LINE   (MAX_LINE)
    ) u_issue (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .len_i        (len),
        .r_i          (r_eff),
        .win_i        (win),
        .start_i      (start_ptr),
        .frame_i      (frame_len),
        .line_clear_i (line_clear),
        .ready_b_i    (ready_b),
        .op_valid_o   (op_valid),
        .op_o         (op),
        .mem_we_o     (mem_we),
        .mem_waddr_o  (mem_waddr),
        .mem_re_o     (mem_re),
        .mem_raddr_o  (mem_raddr)
    );

    // The leaving pixel is read in the issue cycle into a registered read port.
    bblur_wmem #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_wmem (
        .aclk    (aclk),
        .we_i    (mem_we),
        .waddr_i (mem_waddr),
        .wdata_i (s_tdata),
        .re_i    (mem_re),
        .raddr_i (mem_raddr),
        .rdata_o (mem_rdata)
    );

    bblur_accum #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_accum (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .op_valid_i   (op_valid),
        .op_i         (op),
        .rdata_i      (mem_rdata),
        .win_i        (win),
        .line_clear_i (line_clear),
        .c_ready_i    (c_ready),
        .ready_b_o    (ready_b),
        .res_valid_o  (res_valid),
        .res_sums_o   (res_sums),
        .res_flags_o  (res_flags)
    );

    // Multiply, round half up, clamp to a byte and hold for the sink.
    bblur_scale u_scale (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .res_valid_i (res_valid),
        .res_sums_i  (res_sums),
        .res_flags_i (res_flags),
        .recip_i     (recip),
        .c_ready_o   (c_ready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

>>> rtl/bblur_cfg.sv
// Configuration registers and the effective line geometry derived from them.
module bblur_cfg #(
    parameter int MAX_RADIUS = 31,
    parameter int MAX_LINE   = 4096
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [bblur_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bblur_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output logic [$clog2(MAX_LINE+1)-1:0]      len_o,
    output logic [$clog2(MAX_RADIUS+1)-1:0]    r_o,
    output logic [$clog2(MAX_RADIUS+1):0]      win_o,
    output logic [$clog2(2*MAX_RADIUS+1)-1:0]  start_o,
    output logic [bblur_pkg::FRAME_CFG_W-1:0]  frame_o,
    output logic [bblur_pkg::RECIP_W-1:0]      recip_o,
    output logic                               line_clear_o
);
    import bblur_pkg::*;

    localparam int LEN_W = $clog2(MAX_LINE + 1);
    localparam int CW    = (LEN_W > LEN_CFG_W) ? LEN_W : LEN_CFG_W;
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int WW    = RW + 1;
    localparam int DEPTH = 2 * MAX_RADIUS + 1;
    localparam int PTR_W = $clog2(DEPTH);

    // Zero means one pixel, anything above the line buffer limit saturates.
    function automatic logic [CW-1:0] sat_len(input logic [LEN_CFG_W-1:0] v);
        logic [CW-1:0] w;
        w = CW'(v);
        if (w == '0) begin
            w = CW'(1);
        end else if (w > CW'(MAX_LINE)) begin
            w = CW'(MAX_LINE);
        end
        return w;
    endfunction

    // The window may never reach past both ends of the line at once.
    function automatic logic [CW-1:0] eff_radius(input logic [RAD_CFG_W-1:0] rad,
                                                 input logic [CW-1:0] len);
        logic [CW-1:0] r;
        logic [CW-1:0] h;
        r = CW'(rad);
        h = (len - CW'(1)) >> 1;
        if (r > CW'(MAX_RADIUS)) begin
            r = CW'(MAX_RADIUS);
        end
        if (r > h) begin
            r = h;
        end
        return r;
    endfunction

    logic [LEN_W-1:0]       len_reg,     len_next;
    logic [RAD_CFG_W-1:0]   rad_raw_reg, rad_raw_next;
    logic [RW-1:0]          r_reg,       r_next;
    logic [FRAME_CFG_W-1:0] frame_reg,   frame_next;
    logic [RECIP_W-1:0]     recip_reg,   recip_next;
    logic [CW-1:0]          new_len;
    logic [FRAME_CFG_W-1:0] new_frame;

    always_comb begin
        len_next     = len_reg;
        rad_raw_next = rad_raw_reg;
        r_next       = r_reg;
        frame_next   = frame_reg;
        recip_next   = recip_reg;
        line_clear_o = 1'b0;
        new_len      = sat_len(cfg_wdata[LEN_CFG_W-1:0]);
        new_frame    = cfg_wdata[FRAME_CFG_W-1:0];
        if (new_frame == '0) begin
            new_frame = FRAME_CFG_W'(1);
        end else if (new_frame > FRAME_CFG_W'(FRAME_LINES_MAX)) begin
            new_frame = FRAME_CFG_W'(FRAME_LINES_MAX);
        end
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_LINE_LENGTH: begin
                    len_next     = LEN_W'(new_len);
                    r_next       = RW'(eff_radius(rad_raw_reg, new_len));
                    line_clear_o = 1'b1;
                end
                REG_LINES_PER_FRAME: begin
                    frame_next = new_frame;
                end
                REG_RADIUS: begin
                    rad_raw_next = cfg_wdata[RAD_CFG_W-1:0];
                    r_next       = RW'(eff_radius(cfg_wdata[RAD_CFG_W-1:0], CW'(len_reg)));
                    line_clear_o = 1'b1;
                end
                REG_WINDOW_RECIP: begin
                    recip_next = cfg_wdata[RECIP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= LEN_W'(sat_len(LEN_CFG_W'(LEN_RESET)));
            rad_raw_reg <= RAD_CFG_W'(RAD_RESET);
            r_reg       <= RW'(eff_radius(RAD_CFG_W'(RAD_RESET),
                                          sat_len(LEN_CFG_W'(LEN_RESET))));
            frame_reg   <= FRAME_CFG_W'(FRAME_RESET);
            recip_reg   <= RECIP_W'(RECIP_RESET);
        end else begin
            len_reg     <= len_next;
            rad_raw_reg <= rad_raw_next;
            r_reg       <= r_next;
            frame_reg   <= frame_next;
            recip_reg   <= recip_next;
        end
    end

    assign len_o   = len_reg;
    assign r_o     = r_reg;
    assign win_o   = {r_reg, 1'b1};
    assign start_o = PTR_W'(WW'(DEPTH) - win_o);
    assign frame_o = frame_reg;
    assign recip_o = recip_reg;

endmodule

>>> rtl/bblur_wmem.sv
// Window memory: past pixels of the current line, one write and one registered read port.
module bblur_wmem #(
    parameter int MAX_RADIUS = 31
) (
    input  logic                               aclk,
    input  logic                               we_i,
    input  logic [$clog2(2*MAX_RADIUS+1)-1:0]  waddr_i,
    input  logic [bblur_pkg::PIX_W-1:0]        wdata_i,
    input  logic                               re_i,
    input  logic [$clog2(2*MAX_RADIUS+1)-1:0]  raddr_i,
    output logic [bblur_pkg::PIX_W-1:0]        rdata_o
);
    import bblur_pkg::*;

    localparam int DEPTH = 2 * MAX_RADIUS + 1;

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rdata_reg;

    // A read of the entry being written returns the old contents.
    always_ff @(posedge aclk) begin
        if (we_i) begin
            mem[waddr_i] <= wdata_i;
        end
        if (re_i) begin
            rdata_reg <= mem[raddr_i];
        end
    end

    assign rdata_o = rdata_reg;

endmodule

>>> rtl/bblur_issue.sv
// Column sequencer: accepts pixels, runs the end-of-line flush and drives the window memory.
module bblur_issue #(
    parameter int MAX_RADIUS = 31,
    parameter int MAX_LINE   = 4096
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [bblur_pkg::PIX_W-1:0]        s_tdata,
    input  logic [$clog2(MAX_LINE+1)-1:0]      len_i,
    input  logic [$clog2(MAX_RADIUS+1)-1:0]    r_i,
    input  logic [$clog2(MAX_RADIUS+1):0]      win_i,
    input  logic [$clog2(2*MAX_RADIUS+1)-1:0]  start_i,
    input  logic [bblur_pkg::FRAME_CFG_W-1:0]  frame_i,
    input  logic                               line_clear_i,
    input  logic                               ready_b_i,
    output logic                               op_valid_o,
    output bblur_pkg::bblur_op_t               op_o,
    output logic                               mem_we_o,
    output logic [$clog2(2*MAX_RADIUS+1)-1:0]  mem_waddr_o,
    output logic                               mem_re_o,
    output logic [$clog2(2*MAX_RADIUS+1)-1:0]  mem_raddr_o
);
    import bblur_pkg::*;

    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int WW    = RW + 1;
    localparam int DEPTH = 2 * MAX_RADIUS + 1;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int COL_W = $clog2(MAX_LINE + MAX_RADIUS);
    localparam int KW    = (COL_W > WW) ? COL_W : WW;

    function automatic logic [PTR_W-1:0] inc_ptr(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (p == PTR_W'(DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + PTR_W'(1);
        end
        return q;
    endfunction

    logic [COL_W-1:0]      col_reg,    col_next;
    logic [PTR_W-1:0]      wptr_reg,   wptr_next;
    logic [PTR_W-1:0]      rptr_reg,   rptr_next;
    logic                  flush_reg,  flush_next;
    logic [RW-1:0]         remain_reg, remain_next;
    logic                  fend_reg,   fend_next;
    logic [LINE_CNT_W-1:0] lines_reg,  lines_next;
    logic [PIX_W-1:0]      hold_reg;

    logic             pix_fire;
    logic             flush_fire;
    logic             first;
    logic             use_mem;
    logic             at_r;
    logic             at_end;
    logic             r_zero;
    logic             fend;
    logic             last_step;
    logic [PTR_W-1:0] rd_addr;
    logic [PTR_W-1:0] wr_addr;

    always_comb begin
        s_tready   = ready_b_i && !flush_reg;
        pix_fire   = s_tvalid && s_tready;
        flush_fire = flush_reg && ready_b_i;
        first      = (col_reg == '0);
        use_mem    = (KW'(col_reg) >= KW'(win_i));
        at_r       = (KW'(col_reg) >= KW'(r_i));
        at_end     = (KW'(col_reg) >= KW'(len_i) - KW'(1));
        r_zero     = (r_i == '0);
        fend       = (FRAME_CFG_W'(lines_reg) + FRAME_CFG_W'(1) >= frame_i);
        last_step  = (remain_reg == RW'(1));
        rd_addr    = (first && !flush_reg) ? start_i : rptr_reg;
        wr_addr    = first ? '0 : wptr_reg;

        op_o = '0;
        if (flush_reg) begin
            op_o.pix             = hold_reg;
            op_o.use_mem         = use_mem;
            op_o.emit            = 1'b1;
            op_o.flags.line_end  = last_step;
            op_o.flags.frame_end = last_step && fend_reg;
            op_o.flags.run_last  = last_step;
        end else begin
            op_o.pix             = s_tdata;
            op_o.first           = first;
            op_o.use_mem         = use_mem;
            op_o.emit            = at_r;
            op_o.flags.line_end  = at_end && r_zero;
            op_o.flags.frame_end = at_end && r_zero && fend;
            op_o.flags.run_last  = at_r && (!at_end || r_zero);
        end
        op_valid_o  = flush_reg || s_tvalid;
        mem_re_o    = op_valid_o && ready_b_i;
        mem_raddr_o = rd_addr;
        mem_we_o    = pix_fire;
        mem_waddr_o = wr_addr;
    end

    always_comb begin
        col_next    = col_reg;
        wptr_next   = wptr_reg;
        rptr_next   = rptr_reg;
        flush_next  = flush_reg;
        remain_next = remain_reg;
        fend_next   = fend_reg;
        lines_next  = lines_reg;
        if (line_clear_i) begin
            col_next    = '0;
            flush_next  = 1'b0;
            remain_next = '0;
        end else if (pix_fire) begin
            rptr_next = inc_ptr(rd_addr);
            wptr_next = inc_ptr(wr_addr);
            col_next  = col_reg + COL_W'(1);
            if (at_end) begin
                fend_next  = fend;
                lines_next = fend ? '0 : lines_reg + LINE_CNT_W'(1);
                if (r_zero) begin
                    col_next = '0;
                end else begin
                    flush_next  = 1'b1;
                    remain_next = r_i;
                end
            end
        end else if (flush_fire) begin
            rptr_next   = inc_ptr(rptr_reg);
            remain_next = remain_reg - RW'(1);
            if (last_step) begin
                flush_next = 1'b0;
                col_next   = '0;
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            wptr_reg   <= '0;
            rptr_reg   <= '0;
            flush_reg  <= 1'b0;
            remain_reg <= '0;
            fend_reg   <= 1'b0;
            lines_reg  <= '0;
        end else begin
            col_reg    <= col_next;
            wptr_reg   <= wptr_next;
            rptr_reg   <= rptr_next;
            flush_reg  <= flush_next;
            remain_reg <= remain_next;
            fend_reg   <= fend_next;
            lines_reg  <= lines_next;
        end
    end

    // The last pixel of a line is replayed for every flush step.
    always_ff @(posedge aclk) begin
        if (pix_fire && at_end) begin
            hold_reg <= s_tdata;
        end
    end

endmodule

>>> rtl/bblur_accum.sv
// Running sums: one add and one subtract per channel per step past a line's first.
module bblur_accum #(
    parameter int MAX_RADIUS = 31
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        op_valid_i,
    input  bblur_pkg::bblur_op_t                        op_i,
    input  logic [bblur_pkg::PIX_W-1:0]                 rdata_i,
    input  logic [$clog2(MAX_RADIUS+1):0]               win_i,
    input  logic                                        line_clear_i,
    input  logic                                        c_ready_i,
    output logic                                        ready_b_o,
    output logic                                        res_valid_o,
    output logic [bblur_pkg::CHANNELS*bblur_pkg::SUM_W-1:0] res_sums_o,
    output bblur_pkg::bblur_flags_t                     res_flags_o
);
    import bblur_pkg::*;

    localparam int WW     = $clog2(MAX_RADIUS + 1) + 1;
    localparam int INIT_W = WW + CH_W;

    logic              b_valid_reg;
    bblur_op_t         b_op_reg;
    logic [SUM_W-1:0]  sums_reg  [CHANNELS];
    logic [SUM_W-1:0]  sums_next [CHANNELS];
    logic [PIX_W-1:0]  first_pix_reg;

    logic              b_leave;
    logic              load;
    logic [PIX_W-1:0]  leave_pix;
    logic [CH_W-1:0]   px   [CHANNELS];
    logic [CH_W-1:0]   lv   [CHANNELS];
    logic [INIT_W-1:0] init [CHANNELS];

    always_comb begin
        b_leave   = b_valid_reg && (!b_op_reg.emit || c_ready_i);
        ready_b_o = !b_valid_reg || b_leave;
        load      = op_valid_i && ready_b_o;
        // Before the window has filled, the pixel leaving it is the line's first.
        leave_pix = b_op_reg.use_mem ? rdata_i : first_pix_reg;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            px[ch]   = b_op_reg.pix[ch*CH_W +: CH_W];
            lv[ch]   = leave_pix[ch*CH_W +: CH_W];
            init[ch] = INIT_W'(win_i) * INIT_W'(px[ch]);
            if (b_op_reg.first) begin
                sums_next[ch] = SUM_W'(init[ch]);
            end else begin
                sums_next[ch] = sums_reg[ch] + SUM_W'(px[ch]) - SUM_W'(lv[ch]);
            end
            res_sums_o[ch*SUM_W +: SUM_W] = sums_next[ch];
        end
        res_valid_o = b_valid_reg && b_op_reg.emit;
        res_flags_o = b_op_reg.flags;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg   <= 1'b0;
            first_pix_reg <= '0;
            for (int ch = 0; ch < CHANNELS; ch++) begin
                sums_reg[ch] <= '0;
            end
        end else if (line_clear_i) begin
            b_valid_reg <= 1'b0;
            for (int ch = 0; ch < CHANNELS; ch++) begin
                sums_reg[ch] <= '0;
            end
        end else begin
            if (load) begin
                b_valid_reg <= 1'b1;
            end else if (b_leave) begin
                b_valid_reg <= 1'b0;
            end
            if (b_leave) begin
                for (int ch = 0; ch < CHANNELS; ch++) begin
                    sums_reg[ch] <= sums_next[ch];
                end
                if (b_op_reg.first) begin
                    first_pix_reg <= b_op_reg.pix;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            b_op_reg <= op_i;
        end
    end

endmodule

>>> rtl/bblur_scale.sv
// Scaling of window sums by the reciprocal, rounding, saturation and the output register.
module bblur_scale (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        res_valid_i,
    input  logic [bblur_pkg::CHANNELS*bblur_pkg::SUM_W-1:0] res_sums_i,
    input  bblur_pkg::bblur_flags_t                     res_flags_i,
    input  logic [bblur_pkg::RECIP_W-1:0]               recip_i,
    output logic                                        c_ready_o,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    output logic [bblur_pkg::PIX_W-1:0]                 m_tdata,
    output logic [bblur_pkg::USER_W-1:0]                m_tuser,
    output logic                                        m_tlast
);
    import bblur_pkg::*;

    localparam int Q_W = PROD_W + 1 - FRAC_W;

    logic                      c_valid_reg;
    logic [CHANNELS*SUM_W-1:0] c_sums_reg;
    bblur_flags_t              c_flags_reg;
    logic                      d_valid_reg;
    logic [PROD_W-1:0]         d_prod_reg [CHANNELS];
    bblur_flags_t              d_flags_reg;
    logic                      o_valid_reg;
    logic [PIX_W-1:0]          o_data_reg;
    bblur_flags_t              o_flags_reg;

    logic                      out_ready;
    logic                      d_ready;
    logic [PROD_W-1:0]         prod    [CHANNELS];
    logic [PROD_W:0]           rounded [CHANNELS];
    logic [Q_W-1:0]            q       [CHANNELS];
    logic [PIX_W-1:0]          o_data_next;

    always_comb begin
        out_ready = !o_valid_reg || m_tready;
        d_ready   = !d_valid_reg || out_ready;
        c_ready_o = !c_valid_reg || d_ready;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            prod[ch]    = PROD_W'(c_sums_reg[ch*SUM_W +: SUM_W]) * PROD_W'(recip_i);
            rounded[ch] = (PROD_W+1)'(d_prod_reg[ch]) + ((PROD_W+1)'(1) << (FRAC_W - 1));
            q[ch]       = rounded[ch][PROD_W:FRAC_W];
            if (q[ch] > Q_W'(8'hFF)) begin
                o_data_next[ch*CH_W +: CH_W] = 8'hFF;
            end else begin
                o_data_next[ch*CH_W +: CH_W] = q[ch][CH_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            if (c_ready_o) begin
                c_valid_reg <= res_valid_i;
            end
            if (d_ready) begin
                d_valid_reg <= c_valid_reg;
            end
            if (out_ready) begin
                o_valid_reg <= d_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid_i && c_ready_o) begin
            c_sums_reg  <= res_sums_i;
            c_flags_reg <= res_flags_i;
        end
        if (c_valid_reg && d_ready) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                d_prod_reg[ch] <= prod[ch];
            end
            d_flags_reg <= c_flags_reg;
        end
        if (d_valid_reg && out_ready) begin
            o_data_reg  <= o_data_next;
            o_flags_reg <= d_flags_reg;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = o_data_reg;
    assign m_tuser  = {o_flags_reg.frame_end, o_flags_reg.line_end};
    assign m_tlast  = o_flags_reg.run_last;

endmodule

>>> bench/box_blur_line_pass_checker.sv
// Checker for the box blur line pass: predicts blurred pixels and compares them.
`timescale 1ns / 1ps

module box_blur_line_pass_checker
    import bblur_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [PIX_W-1:0]      s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [PIX_W-1:0]      m_tdata,
    input  logic [USER_W-1:0]     m_tuser,
    input  logic                  m_tlast,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  stimulus_done,
    output int                    error_count,
    output int                    results_pending
);

    localparam int LONGEST_LINE = 4096;
    localparam int WIDEST_RAD   = 31;
    localparam int HISTORY      = 2 * WIDEST_RAD + 1;
    localparam int MOST_SHOWN   = 40;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             line_end;
        logic             frame_end;
        logic             run_last;
    } blurred_t;

    logic [LEN_CFG_W-1:0]   line_len_cfg;
    logic [FRAME_CFG_W-1:0] frame_len_cfg;
    logic [RAD_CFG_W-1:0]   radius_cfg;
    logic [RECIP_W-1:0]     recip_cfg;

    logic [PIX_W-1:0] past_pix [HISTORY];
    logic [SUM_W-1:0] win_sum [CHANNELS];
    logic [PIX_W-1:0] first_pix;
    logic [11:0]      in_col;
    logic [11:0]      out_col;
    logic [11:0]      line_cnt;

    blurred_t blurred_q [$];
    blurred_t want;
    int       shown;
    logic     leftover_checked = 1'b0;

    function automatic int active_length();
        int l;
        l = line_len_cfg;
        if (l == 0) l = 1;
        if (l > LONGEST_LINE) l = LONGEST_LINE;
        return l;
    endfunction

    function automatic int active_radius();
        int r;
        r = radius_cfg;
        if (r > WIDEST_RAD) r = WIDEST_RAD;
        if (r > (active_length() - 1) / 2) r = (active_length() - 1) / 2;
        return r;
    endfunction

    function automatic int active_frame();
        int f;
        f = frame_len_cfg;
        if (f == 0) f = 1;
        if (f > FRAME_LINES_MAX) f = FRAME_LINES_MAX;
        return f;
    endfunction

    task automatic restart_line();
        int ch;
        for (ch = 0; ch < CHANNELS; ch++) win_sum[ch] = '0;
        in_col  = '0;
        out_col = '0;
    endtask

    // One pixel enters the window sums and one leaves; the sums wrap at 14 bits.
    task automatic slide(input logic [PIX_W-1:0] entering, input logic [PIX_W-1:0] leaving);
        int ch;
        for (ch = 0; ch < CHANNELS; ch++)
            win_sum[ch] = win_sum[ch] + entering[8*ch +: 8] - leaving[8*ch +: 8];
    endtask

    // Rounded-half-up Q1.24 product per channel, saturated to a byte.
    task automatic average_window(output blurred_t res);
        int ch;
        logic [63:0] prod;
        res = '0;
        for (ch = 0; ch < CHANNELS; ch++) begin
            prod = 64'(win_sum[ch]) * 64'(recip_cfg) + 64'd8388608;
            prod = prod >> 24;
            res.pix[8*ch +: 8] = (prod > 64'd255) ? 8'hFF : prod[7:0];
        end
        out_col = out_col + 1'b1;
    endtask

    task automatic blur_pixel(input logic [PIX_W-1:0] pix);
        blurred_t         produced [WIDEST_RAD + 1];
        logic [PIX_W-1:0] leaving;
        logic             frame_done;
        int               len, r, c, n, j, k, ch;
        len = active_length();
        r   = active_radius();
        c   = in_col;
        n   = 0;
        if (c == 0) begin
            first_pix = pix;
            out_col   = '0;
            for (ch = 0; ch < CHANNELS; ch++)
                win_sum[ch] = SUM_W'((2 * r + 1) * int'(pix[8*ch +: 8]));
        end else begin
            leaving = (c >= 2 * r + 1) ? past_pix[(c - 2 * r - 1) % HISTORY] : first_pix;
            slide(pix, leaving);
        end
        past_pix[c % HISTORY] = pix;
        if (c >= r) begin
            average_window(produced[n]);
            n++;
        end
        if (c >= len - 1) begin
            // Flush: the right-hand neighbours all repeat the last pixel.
            for (k = 0; k < r; k++) begin
                j = out_col;
                leaving = (j >= r + 1) ? past_pix[(j - r - 1) % HISTORY] : first_pix;
                slide(pix, leaving);
                average_window(produced[n]);
                n++;
            end
            frame_done = (int'(line_cnt) + 1 >= active_frame());
            if (n > 0) begin
                produced[n-1].line_end  = 1'b1;
                produced[n-1].frame_end = frame_done;
            end
            line_cnt = frame_done ? 12'd0 : line_cnt + 1'b1;
            in_col   = '0;
            out_col  = '0;
        end else begin
            in_col = in_col + 1'b1;
        end
        if (n > 0) produced[n-1].run_last = 1'b1;
        for (k = 0; k < n; k++) blurred_q = {blurred_q, produced[k]};
    endtask

    task automatic report_mismatch(input string field, input logic [7:0] expv,
                                   input logic [7:0] actv);
        error_count++;
        if (shown < MOST_SHOWN) begin
            shown++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, expv, actv);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            line_len_cfg  = LEN_CFG_W'(LEN_RESET);
            frame_len_cfg = FRAME_CFG_W'(FRAME_RESET);
            radius_cfg    = RAD_CFG_W'(RAD_RESET);
            recip_cfg     = RECIP_W'(RECIP_RESET);
            first_pix     = '0;
            line_cnt      = '0;
            restart_line();
            blurred_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_LINE_LENGTH: begin
                        line_len_cfg = cfg_wdata[LEN_CFG_W-1:0];
                        restart_line();
                    end
                    REG_LINES_PER_FRAME: frame_len_cfg = cfg_wdata[FRAME_CFG_W-1:0];
                    REG_RADIUS: begin
                        radius_cfg = cfg_wdata[RAD_CFG_W-1:0];
                        restart_line();
                    end
                    REG_WINDOW_RECIP: recip_cfg = cfg_wdata[RECIP_W-1:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) blur_pixel(s_tdata);

            if (m_tvalid && m_tready) begin
                if (blurred_q.size() == 0) begin
                    error_count++;
                    if (shown < MOST_SHOWN) begin
                        shown++;
                        $display("%0t: unexpected result, expected none, got %h user %b last %b",
                                 $time, m_tdata, m_tuser, m_tlast);
                    end
                end else begin
                    want = blurred_q.pop_front();
                    for (int ch = 0; ch < CHANNELS; ch++)
                        if (m_tdata[8*ch +: 8] !== want.pix[8*ch +: 8])
                            report_mismatch($sformatf("out_ch%0d", ch),
                                            want.pix[8*ch +: 8], m_tdata[8*ch +: 8]);
                    if (m_tuser[0] !== want.line_end)
                        report_mismatch("line_end", 8'(want.line_end), 8'(m_tuser[0]));
                    if (m_tuser[1] !== want.frame_end)
                        report_mismatch("frame_end", 8'(want.frame_end), 8'(m_tuser[1]));
                    if (m_tlast !== want.run_last)
                        report_mismatch("run_last", 8'(want.run_last), 8'(m_tlast));
                end
            end

            if (stimulus_done && !leftover_checked) begin
                leftover_checked = 1'b1;
                if (blurred_q.size() != 0) begin
                    error_count++;
                    $display("%0t: results missing, expected %0d more, got none",
                             $time, blurred_q.size());
                end
            end
        end
        results_pending = blurred_q.size();
    end

endmodule

>>> bench/box_blur_line_pass_tb.sv
// Top of the box blur line pass testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module box_blur_line_pass_tb;
    import bblur_pkg::*;

    // Cycles without any transaction before the run is declared hung. The
    // longest legitimate quiet stretch is the deliberate output hold-off.
    localparam int STALL_LIMIT = 2000;
    localparam int SINK_HOLD   = 300;
    localparam int ITEM_BUDGET = 470;
    // A pixel's result passes the window sum, snapshot, product and rounding
    // registers, and a line end adds the flush; this is what we let pass after
    // the last result before touching the registers.
    localparam int SETTLE      = 20;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [PIX_W-1:0]      m_tdata;
    logic [USER_W-1:0]     m_tuser;
    logic                  m_tlast;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    logic no_gaps;
    logic hold_req;
    logic stimulus_done;
    int   error_count;
    int   results_pending;
    int   quiet_cycles;

    box_blur_line_pass u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    box_blur_line_pass_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .stimulus_done   (stimulus_done),
        .error_count     (error_count),
        .results_pending (results_pending)
    );

    initial begin : clock_gen
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // The watchdog only counts cycles in which no transaction of any kind
    // completes, so slow but progressing runs never trip it.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        quiet_cycles = 0;
        wait (quiet_cycles >= STALL_LIMIT);
        $display("FAIL box_blur_line_pass");
        $finish;
    end

    // Offers one pixel, after a random gap unless the current phase runs
    // without gaps, and returns at the falling edge after its transaction.
    // Valid stays high when the next pixel follows with no gap, so it is
    // never lowered and raised within the same time step.
    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Stops offering pixels until every predicted result has come out, then
    // lets a few more cycles pass so pixels that produce no result (the ones
    // before the window fills) have left the pipeline as well.
    task automatic drain_results(input int extra);
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (results_pending != 0) @(negedge aclk);
        repeat (extra) @(negedge aclk);
    endtask

    // Between register writes the enable is lowered again, so it never gets
    // two assignments in one time step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Result side: a random stall before each transaction, none at all in
    // gap-free phases, and one long hold-off on request so the block fills
    // up and has to push back on its input.
    initial begin : result_sink
        int unsigned gap;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                gap = SINK_HOLD;
            end else if (no_gaps) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, 11);
            end
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        int          sent;
        int          phase;
        int unsigned len_raw, rad_raw, len_eff, rad_eff, window, recip;
        int          n_lines, partial;

        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_wr_en     = 1'b0;
        cfg_index     = REG_LINE_LENGTH;
        cfg_wdata     = '0;
        no_gaps       = 1'b0;
        hold_req      = 1'b0;
        stimulus_done = 1'b0;
        sent          = 0;
        phase         = 0;

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset geometry (4096-pixel line, radius 1): extreme and alternating
        // channel bytes. The line stays open and is abandoned later.
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h00FF_00FF);
        send_pixel(32'hFF00_FF00);
        send_pixel(32'h0F0F_0F0F);
        send_pixel(32'hF0F0_F0F0);
        drain_results(SETTLE);

        // Radius change in the middle of a line, to the widest window. The
        // next three pixels sit before the window fills and yield nothing.
        write_reg(REG_RADIUS, 31);
        write_reg(REG_WINDOW_RECIP, 266305);
        write_reg(REG_LINES_PER_FRAME, 0);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h8000_0001);
        send_pixel(32'h7F7F_7F7F);
        drain_results(SETTLE);

        // A line length of zero acts as one pixel, which forces the radius
        // down to zero; every pixel is a whole line and, with zero lines per
        // frame acting as one, also a whole frame. Full-scale reciprocal.
        write_reg(REG_LINE_LENGTH, 0);
        write_reg(REG_RADIUS, 3);
        write_reg(REG_WINDOW_RECIP, 1 << 24);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0000_0000);
        send_pixel(32'h1234_5678);
        drain_results(SETTLE);

        // Radius far beyond what a five-pixel line allows, and the largest
        // reciprocal, so bright windows saturate at 255.
        write_reg(REG_LINE_LENGTH, 5);
        write_reg(REG_RADIUS, 31);
        write_reg(REG_WINDOW_RECIP, 25'h1FF_FFFF);
        write_reg(REG_LINES_PER_FRAME, 2);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0101_0101);
        send_pixel(32'h0000_0000);
        send_pixel(32'h8080_8080);
        drain_results(SETTLE);

        // Line length above the maximum saturates; a short partial line only.
        write_reg(REG_LINE_LENGTH, 8191);
        write_reg(REG_RADIUS, 2);
        write_reg(REG_WINDOW_RECIP, 3355443);
        repeat (5) send_pixel($urandom());
        sent = 22;

        // Random phases: each writes a new geometry (which also abandons any
        // partial line), then sends whole lines of random pixels and now and
        // then a broken line that the next phase cuts off. Sending stops
        // wherever the item budget runs out.
        while (sent < ITEM_BUDGET) begin
            phase++;
            drain_results(SETTLE);

            case ($urandom_range(0, 15))
                0:       len_raw = 0;
                1:       len_raw = 1;
                2:       len_raw = 8191;
                3:       len_raw = $urandom_range(65, 160);
                default: len_raw = $urandom_range(2, 40);
            endcase
            rad_raw = $urandom_range(0, 1) ? $urandom_range(0, 31) : $urandom_range(0, 4);
            // The pressure phase: a long line sent flat out while the sink
            // holds off, so the block has to stall its input.
            if (phase == 2) begin
                len_raw = 100;
                rad_raw = 3;
            end
            len_eff = (len_raw == 0) ? 1 : ((len_raw > 4096) ? 4096 : len_raw);
            rad_eff = (rad_raw > (len_eff - 1) / 2) ? (len_eff - 1) / 2 : rad_raw;
            window  = 2 * rad_eff + 1;

            case ($urandom_range(0, 7))
                0:       recip = $urandom_range(0, (1 << 25) - 1);
                1:       recip = 0;
                default: recip = ((1 << 24) + window / 2) / window;
            endcase

            write_reg(REG_LINE_LENGTH, len_raw);
            write_reg(REG_RADIUS, rad_raw);
            write_reg(REG_WINDOW_RECIP, recip);
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_LINES_PER_FRAME,
                          ($urandom_range(0, 5) == 0) ? 8191 : $urandom_range(0, 4));

            no_gaps = ($urandom_range(0, 3) == 0) || (phase == 2);
            if (phase == 2) hold_req = 1'b1;

            n_lines = (len_raw == 8191) ? 0 : ((len_eff > 40) ? 1 : $urandom_range(1, 3));
            for (int line = 0; line < n_lines && sent < ITEM_BUDGET; line++) begin
                for (int col = 0; col < len_eff && sent < ITEM_BUDGET; col++) begin
                    // Once, the sender waits mid-line until the pipeline is empty.
                    if (phase == 5 && line == 0 && col == len_eff / 2) drain_results(0);
                    send_pixel($urandom());
                    sent++;
                end
            end

            partial = 0;
            if (len_raw == 8191) begin
                partial = $urandom_range(5, 40);
            end else if (len_eff > 1 && $urandom_range(0, 3) == 0) begin
                partial = $urandom_range(1, len_eff - 1);
            end
            repeat (partial) begin
                if (sent < ITEM_BUDGET) begin
                    send_pixel($urandom());
                    sent++;
                end
            end
            no_gaps = 1'b0;
        end

        drain_results(SETTLE);
        stimulus_done = 1'b1;
        @(negedge aclk);
        if (error_count == 0) begin
            $display("PASS box_blur_line_pass");
        end else begin
            $display("FAIL box_blur_line_pass");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/bblur_pkg.sv
rtl/bblur_cfg.sv
rtl/bblur_wmem.sv
rtl/bblur_issue.sv
rtl/bblur_accum.sv
rtl/bblur_scale.sv
rtl/box_blur_line_pass.sv
bench/box_blur_line_pass_checker.sv
bench/box_blur_line_pass_tb.sv
